/* rtl/bba_pkg.sv */
// Shared constants for the buddy block allocator.
package bba_pkg;

    localparam int MAX_POOL_ORDER_DEF = 16;
    localparam int MIN_UNIT_ORDER_DEF = 4;
    localparam int HEADER_BYTES       = 8;

    localparam int POOL_ORDER_LO  = 10;
    localparam int POOL_ORDER_RST = 10;
    localparam int MIN_ORDER_HI   = 10;

    // block_info entry layout
    localparam int BI_W        = 7;
    localparam int BI_START_B  = 6;
    localparam int BI_USED_B   = 5;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAIL     = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;

    // configuration register indexes
    localparam logic [1:0] CFG_POOL_ORDER = 2'd0;
    localparam logic [1:0] CFG_MIN_ORDER  = 2'd1;

endpackage

/* rtl/buddy_block_allocator.sv */
// Binary buddy allocator: block info memory, free-node bitmap and request sequencer.
// Throughput: one item at a time; busy stays high until the result strobe.
// The result sits on the o_ ports for one cycle with o_valid; the receiver cannot stall.
// Reset (synchronous, active low) or a pool/min-order config write starts a clearing
// pass over 2^(MAX_POOL_ORDER-MIN_UNIT_ORDER) units (4096 by default) with busy high.
module buddy_block_allocator #(
    parameter int MAX_POOL_ORDER = bba_pkg::MAX_POOL_ORDER_DEF,
    parameter int MIN_UNIT_ORDER = bba_pkg::MIN_UNIT_ORDER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [16:0] i_request_size,
    input  logic [15:0] i_address,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_address_res,
    output logic [4:0]  o_block_order,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [4:0]  i_cfg_wdata
);

    // Widths. Offsets are OW bits, one block_info entry per 2^MIN_UNIT_ORDER unit,
    // the free tree has 2^TW nodes packed FWW to a memory word.
    localparam int OW  = MAX_POOL_ORDER;
    localparam int UW  = OW - MIN_UNIT_ORDER;
    localparam int TW  = UW + 1;
    localparam int FB  = (TW >= 7) ? 6 : TW - 1;
    localparam int FWW = 1 << FB;
    localparam int WA  = TW - FB;
    localparam int NW  = 1 << WA;
    localparam int NU  = 1 << UW;
    localparam int CW  = (OW + 1 > 18) ? OW + 1 : 18;

    // Sequencer states
    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_A_WANT = 4'd2;   // size -> order walk
    localparam logic [3:0] S_A_RD   = 4'd3;   // read bitmap word of current level
    localparam logic [3:0] S_A_CHK  = 4'd4;   // find lowest free node in word
    localparam logic [3:0] S_A_SPL  = 4'd5;   // split step or grant
    localparam logic [3:0] S_A_SRD  = 4'd6;   // read word for upper half
    localparam logic [3:0] S_A_SWR  = 4'd7;   // mark upper half free
    localparam logic [3:0] S_F_RD   = 4'd8;   // read header info
    localparam logic [3:0] S_F_CHK  = 4'd9;
    localparam logic [3:0] S_F_LOOP = 4'd10;  // read buddy info
    localparam logic [3:0] S_F_BCHK = 4'd11;  // merge decision
    localparam logic [3:0] S_F_MRD  = 4'd12;
    localparam logic [3:0] S_F_MWR  = 4'd13;  // clear buddy node
    localparam logic [3:0] S_F_FRD  = 4'd14;
    localparam logic [3:0] S_F_FWR  = 4'd15;  // set merged node, finish

    // Memories
    logic [bba_pkg::BI_W-1:0] bi_mem [NU];
    logic [FWW-1:0]           fm_mem [NW];

    logic [3:0]    r_state, n_state;
    logic [UW-1:0] r_cnt, n_cnt;
    logic [4:0]    r_pool, n_pool;
    logic [3:0]    r_min, n_min;
    logic [16:0]   r_size, n_size;
    logic [4:0]    r_want, n_want;
    logic [4:0]    r_ord, n_ord;
    logic [OW-1:0] r_off, n_off;
    logic [WA-1:0] r_widx, n_widx;
    logic [TW-1:0] r_node, n_node;
    logic          r_valid, n_valid;
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_ares, n_ares;
    logic [4:0]    r_bord, n_bord;

    logic [bba_pkg::BI_W-1:0] r_bi_q;
    logic [FWW-1:0]           r_fm_q;

    logic                     bi_we, fm_we;
    logic [UW-1:0]            bi_wa, bi_ra;
    logic [bba_pkg::BI_W-1:0] bi_wd;
    logic [WA-1:0]            fm_wa, fm_ra;
    logic [FWW-1:0]           fm_wd;

    logic [4:0]    lvl;
    logic [OW-1:0] bud;
    logic [FWW-1:0] lv_mask, masked;
    logic          ff_hit;
    logic [FB-1:0] ff_bit;
    logic [TW-1:0] nd_found;
    logic [OW-1:0] off_found;
    logic          is_last;
    logic [CW-1:0] pool_w, hdr_w, thr_w;
    logic [4:0]    o2;
    logic [OW-1:0] hi;
    logic [4:0]    cfg_pool;
    logic [3:0]    cfg_min;

    function automatic logic [UW-1:0] unit_of(input logic [OW-1:0] off);
        return off[OW-1:MIN_UNIT_ORDER];
    endfunction

    function automatic logic [TW-1:0] node_of(input logic [OW-1:0] off,
                                              input logic [4:0] ord,
                                              input logic [4:0] pool);
        logic [4:0]  lv;
        logic [OW:0] t;
        lv = pool - ord;
        t  = ({1'b0, off} >> ord) | ((OW + 1)'(1) << lv);
        return t[TW-1:0];
    endfunction

    function automatic logic [WA-1:0] first_word(input logic [4:0] lv);
        logic [WA-1:0] w;
        w = '0;
        if (lv >= 5'(FB)) begin
            w = WA'(1) << 5'(lv - 5'(FB));
        end
        return w;
    endfunction

    assign lvl = r_pool - r_ord;
    assign bud = r_off ^ (OW'(1) << r_ord);
    assign pool_w = CW'(1) << r_pool;
    assign hdr_w  = CW'(i_address) - CW'(bba_pkg::HEADER_BYTES);
    assign thr_w  = (CW'(1) << r_want) - CW'(bba_pkg::HEADER_BYTES);
    assign o2 = r_ord - 5'd1;
    assign hi = r_off | (OW'(1) << o2);

    // Level range within a bitmap word: whole word once the level spans words.
    always_comb begin
        for (int b = 0; b < FWW; b++) begin
            lv_mask[b] = (lvl >= 5'(FB)) || ((((FB + 1)'(b)) >> lvl) == (FB + 1)'(1));
        end
    end
    assign masked = r_fm_q & lv_mask;

    // Lowest set bit
    always_comb begin
        ff_hit = 1'b0;
        ff_bit = '0;
        for (int b = FWW - 1; b >= 0; b--) begin
            if (masked[b]) begin
                ff_hit = 1'b1;
                ff_bit = FB'(b);
            end
        end
    end

    assign nd_found  = {r_widx, ff_bit};
    assign off_found = OW'(nd_found ^ (TW'(1) << lvl)) << r_ord;
    assign is_last   = (lvl < 5'(FB)) ||
                       ((~r_widx & ((WA'(1) << 5'(lvl - 5'(FB))) - WA'(1))) == '0);

    // Saturated config values
    always_comb begin
        cfg_pool = i_cfg_wdata;
        if (cfg_pool < 5'(bba_pkg::POOL_ORDER_LO)) cfg_pool = 5'(bba_pkg::POOL_ORDER_LO);
        if (cfg_pool > 5'(MAX_POOL_ORDER))         cfg_pool = 5'(MAX_POOL_ORDER);
        cfg_min = i_cfg_wdata[3:0];
        if (cfg_min < 4'(MIN_UNIT_ORDER))          cfg_min = 4'(MIN_UNIT_ORDER);
        if (cfg_min > 4'(bba_pkg::MIN_ORDER_HI))   cfg_min = 4'(bba_pkg::MIN_ORDER_HI);
    end

    // Read addresses
    assign fm_ra = (r_state == S_A_RD) ? r_widx : r_node[TW-1:FB];
    assign bi_ra = (r_state == S_F_LOOP) ? unit_of(bud) : unit_of(r_off);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pool   = r_pool;
        n_min    = r_min;
        n_size   = r_size;
        n_want   = r_want;
        n_ord    = r_ord;
        n_off    = r_off;
        n_widx   = r_widx;
        n_node   = r_node;
        n_valid  = 1'b0;
        n_status = r_status;
        n_ares   = r_ares;
        n_bord   = r_bord;
        bi_we = 1'b0;
        bi_wa = unit_of(r_off);
        bi_wd = '0;
        fm_we = 1'b0;
        fm_wa = r_node[TW-1:FB];
        fm_wd = r_fm_q;

        case (r_state)
            S_CLR: begin
                bi_we = 1'b1;
                bi_wa = r_cnt;
                bi_wd = (r_cnt == '0) ? {1'b1, 1'b0, r_pool} : '0;
                fm_we = ((r_cnt >> WA) == '0);
                fm_wa = r_cnt[WA-1:0];
                fm_wd = (r_cnt == '0) ? FWW'(2) : '0;
                n_cnt = r_cnt + UW'(1);
                if (r_cnt == UW'(NU - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_status = bba_pkg::ST_OK;
                    n_ares   = '0;
                    n_bord   = '0;
                    if (i_kind == bba_pkg::KIND_ALLOC) begin
                        if (i_request_size == '0 ||
                            CW'(i_request_size) > pool_w - CW'(bba_pkg::HEADER_BYTES)) begin
                            n_status = bba_pkg::ST_FAIL;
                            n_valid  = 1'b1;
                        end else begin
                            n_size  = i_request_size;
                            n_want  = {1'b0, r_min};
                            n_state = S_A_WANT;
                        end
                    end else begin
                        if (i_address == '0) begin
                            n_valid = 1'b1;
                        end else if (i_address < 16'(bba_pkg::HEADER_BYTES) ||
                                     hdr_w >= pool_w ||
                                     hdr_w[MIN_UNIT_ORDER-1:0] != '0) begin
                            n_status = bba_pkg::ST_BAD_FREE;
                            n_valid  = 1'b1;
                        end else begin
                            n_off   = hdr_w[OW-1:0];
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_A_WANT: begin
                if (thr_w < CW'(r_size)) begin
                    n_want = r_want + 5'd1;
                end else begin
                    n_ord   = r_want;
                    n_widx  = first_word(r_pool - r_want);
                    n_state = S_A_RD;
                end
            end
            S_A_RD: begin
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (ff_hit) begin
                    fm_we   = 1'b1;
                    fm_wa   = r_widx;
                    fm_wd   = r_fm_q & ~(FWW'(1) << ff_bit);
                    n_off   = off_found;
                    n_state = S_A_SPL;
                end else if (!is_last) begin
                    n_widx  = r_widx + WA'(1);
                    n_state = S_A_RD;
                end else if (r_ord == r_pool) begin
                    n_status = bba_pkg::ST_FAIL;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_ord   = r_ord + 5'd1;
                    n_widx  = first_word(lvl - 5'd1);
                    n_state = S_A_RD;
                end
            end
            S_A_SPL: begin
                bi_we = 1'b1;
                if (r_ord == r_want) begin
                    bi_wa    = unit_of(r_off);
                    bi_wd    = {1'b1, 1'b1, r_want};
                    n_ares   = 16'(CW'(r_off) + CW'(bba_pkg::HEADER_BYTES));
                    n_bord   = r_want;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    bi_wa   = unit_of(hi);
                    bi_wd   = {1'b1, 1'b0, o2};
                    n_node  = node_of(hi, o2, r_pool);
                    n_ord   = o2;
                    n_state = S_A_SRD;
                end
            end
            S_A_SRD: begin
                n_state = S_A_SWR;
            end
            S_A_SWR: begin
                fm_we   = 1'b1;
                fm_wd   = r_fm_q | (FWW'(1) << r_node[FB-1:0]);
                n_state = S_A_SPL;
            end
            S_F_RD: begin
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (!r_bi_q[bba_pkg::BI_START_B] || !r_bi_q[bba_pkg::BI_USED_B] ||
                    r_bi_q[4:0] > r_pool || r_bi_q[4:0] < {1'b0, r_min}) begin
                    n_status = bba_pkg::ST_BAD_FREE;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_ord   = r_bi_q[4:0];
                    n_state = S_F_LOOP;
                end
            end
            S_F_LOOP: begin
                if (r_ord >= r_pool) begin
                    bi_we   = 1'b1;
                    bi_wd   = {1'b1, 1'b0, r_ord};
                    n_node  = node_of(r_off, r_ord, r_pool);
                    n_state = S_F_FRD;
                end else begin
                    n_state = S_F_BCHK;
                end
            end
            S_F_BCHK: begin
                bi_we = 1'b1;
                if (!r_bi_q[bba_pkg::BI_START_B] || r_bi_q[bba_pkg::BI_USED_B] ||
                    r_bi_q[4:0] != r_ord) begin
                    // buddy not mergeable: final block stays here
                    bi_wd   = {1'b1, 1'b0, r_ord};
                    n_node  = node_of(r_off, r_ord, r_pool);
                    n_state = S_F_FRD;
                end else begin
                    n_node = node_of(bud, r_ord, r_pool);
                    if (bud < r_off) begin
                        n_off = bud;
                    end else begin
                        bi_wa = unit_of(bud);
                    end
                    n_ord   = r_ord + 5'd1;
                    n_state = S_F_MRD;
                end
            end
            S_F_MRD: begin
                n_state = S_F_MWR;
            end
            S_F_MWR: begin
                fm_we   = 1'b1;
                fm_wd   = r_fm_q & ~(FWW'(1) << r_node[FB-1:0]);
                n_state = S_F_LOOP;
            end
            S_F_FRD: begin
                n_state = S_F_FWR;
            end
            S_F_FWR: begin
                fm_we   = 1'b1;
                fm_wd   = r_fm_q | (FWW'(1) << r_node[FB-1:0]);
                n_bord  = r_ord;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
                n_cnt   = '0;
            end
        endcase

        // A write to the pool or minimum order register reinitializes the pool.
        if (i_cfg_we && (i_cfg_addr == bba_pkg::CFG_POOL_ORDER ||
                         i_cfg_addr == bba_pkg::CFG_MIN_ORDER)) begin
            if (i_cfg_addr == bba_pkg::CFG_POOL_ORDER) begin
                n_pool = cfg_pool;
            end else begin
                n_min = cfg_min;
            end
            n_state = S_CLR;
            n_cnt   = '0;
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_pool  <= 5'(bba_pkg::POOL_ORDER_RST);
            r_min   <= 4'(MIN_UNIT_ORDER);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pool  <= n_pool;
            r_min   <= n_min;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size   <= n_size;
        r_want   <= n_want;
        r_ord    <= n_ord;
        r_off    <= n_off;
        r_widx   <= n_widx;
        r_node   <= n_node;
        r_status <= n_status;
        r_ares   <= n_ares;
        r_bord   <= n_bord;
    end

    // Memory ports: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (bi_we) begin
            bi_mem[bi_wa] <= bi_wd;
        end
        r_bi_q <= bi_mem[bi_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            fm_mem[fm_wa] <= fm_wd;
        end
        r_fm_q <= fm_mem[fm_ra];
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_address_res = r_ares;
    assign o_block_order = r_bord;

endmodule

/* rtl/bba_chk.sv */
// Port-level checker for the buddy block allocator, bound to the top level.
module bba_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [15:0] o_address_res,
    input logic [4:0]  o_block_order
);

    // reset starts the clearing pass and drops any pending result
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy && !o_valid)
        else $error("reset did not start clearing");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != bba_pkg::ST_OK |-> o_address_res == '0 && o_block_order == '0)
        else $error("failed result carries data");

    a_grant_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == bba_pkg::ST_OK && o_address_res != '0
        |-> o_address_res[3:0] == 4'h8)
        else $error("granted offset misaligned");

endmodule

bind buddy_block_allocator bba_chk u_bba_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_address_res (o_address_res),
    .o_block_order (o_block_order)
);

/* dv/tb_buddy_block_allocator.sv */
// Self-checking testbench for the buddy block allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam logic       KIND_FREE   = 1'b1;
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;
    localparam int UNITS      = 1 << (MAX_POOL_ORDER_DEF - MIN_UNIT_ORDER_DEF);
    localparam int NODES      = 2 * UNITS;
    localparam int DRAIN_WAIT = 80;        // idle wait after results drain
    localparam int CYCLE_CAP  = 1_500_000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
        logic [4:0]  order;
    } grant_t;

    typedef struct {
        logic        kind;
        logic [16:0] size;
        logic [15:0] addr;
        bit          typed;       // expected result typed in below
        grant_t      res;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = KIND_ALLOC;
    logic [16:0] i_request_size = '0;
    logic [15:0] i_address = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_address_res;
    logic [4:0]  o_block_order;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [4:0]  i_cfg_wdata = '0;

    buddy_block_allocator dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Allocator model: own copy of pool setup, block headers, free tree
    // ---------------------------------------------------------------
    int unsigned pool_ord, unit_min_ord;
    logic [6:0]  hdr_info [UNITS];   // bit6 start, bit5 used, 4..0 order
    bit          free_node [NODES];

    grant_t      pending_results[$];
    logic [15:0] live_grants[$];     // user offsets currently handed out
    logic [15:0] stale_grants[$];    // offsets already returned, for double frees
    int          n_fail = 0;
    bit          idle_gaps = 1'b1;

    function automatic int unsigned node_idx(int unsigned off, int unsigned ord);
        return ((1 << (pool_ord - ord)) + (off >> ord)) & (NODES - 1);
    endfunction

    function automatic int unsigned unit_idx(int unsigned off);
        return (off >> MIN_UNIT_ORDER_DEF) & (UNITS - 1);
    endfunction

    function automatic void clear_pool();
        foreach (hdr_info[i]) hdr_info[i] = '0;
        foreach (free_node[i]) free_node[i] = 1'b0;
        hdr_info[0] = 7'h40 | 7'(pool_ord);
        free_node[1] = 1'b1;
    endfunction

    function automatic void apply_cfg(logic [1:0] idx, logic [4:0] val);
        int unsigned v;
        v = val;
        if (idx == CFG_POOL_ORDER) begin
            pool_ord = (v < POOL_ORDER_LO) ? POOL_ORDER_LO :
                       (v > MAX_POOL_ORDER_DEF) ? MAX_POOL_ORDER_DEF : v;
            clear_pool();
        end else if (idx == CFG_MIN_ORDER) begin
            v = v & 4'hF;
            unit_min_ord = (v < MIN_UNIT_ORDER_DEF) ? MIN_UNIT_ORDER_DEF :
                           (v > MIN_ORDER_HI) ? MIN_ORDER_HI : v;
            clear_pool();
        end
    endfunction

    function automatic grant_t model_alloc(int unsigned size);
        grant_t r;
        int unsigned want, ord, off, first, hi;
        bit found;
        r = '{ST_FAIL, 16'd0, 5'd0};
        found = 1'b0;
        off = 0;
        if (size == 0 || size > (1 << pool_ord) - HEADER_BYTES) return r;
        want = unit_min_ord;
        while ((1 << want) - HEADER_BYTES < size) want++;
        // lowest-address free block, smallest fitting order first
        for (ord = want; ord <= pool_ord && !found; ord++) begin
            first = 1 << (pool_ord - ord);
            for (int unsigned n = first; n < 2 * first && n < NODES; n++) begin
                if (free_node[n]) begin
                    off = (n - first) << ord;
                    found = 1'b1;
                    break;
                end
            end
        end
        if (!found) return r;
        ord--;
        free_node[node_idx(off, ord)] = 1'b0;
        while (ord > want) begin
            ord--;
            hi = off + (1 << ord);
            hdr_info[unit_idx(hi)] = 7'h40 | 7'(ord);
            free_node[node_idx(hi, ord)] = 1'b1;
        end
        hdr_info[unit_idx(off)] = 7'h60 | 7'(want);
        r = '{ST_OK, 16'(off + HEADER_BYTES), 5'(want)};
        return r;
    endfunction

    function automatic grant_t model_free(int unsigned addr);
        grant_t r;
        int unsigned hdr, ord, bud;
        logic [6:0] info;
        r = '{ST_OK, 16'd0, 5'd0};
        if (addr == 0) return r;            // null pointer
        r.status = ST_BAD_FREE;
        if (addr < HEADER_BYTES) return r;
        hdr = addr - HEADER_BYTES;
        if (hdr >= (1 << pool_ord) || (hdr & ((1 << MIN_UNIT_ORDER_DEF) - 1)) != 0) return r;
        info = hdr_info[unit_idx(hdr)];
        if (!info[BI_START_B] || !info[BI_USED_B]) return r;
        ord = info[4:0];
        if (ord > pool_ord || ord < unit_min_ord) return r;
        // coalesce with equal-size free buddies
        while (ord < pool_ord) begin
            bud = hdr ^ (1 << ord);
            info = hdr_info[unit_idx(bud)];
            if (!info[BI_START_B] || info[BI_USED_B] || info[4:0] != ord) break;
            free_node[node_idx(bud, ord)] = 1'b0;
            if (bud < hdr) begin
                hdr_info[unit_idx(hdr)] = '0;
                hdr = bud;
            end else begin
                hdr_info[unit_idx(bud)] = '0;
            end
            ord++;
        end
        hdr_info[unit_idx(hdr)] = 7'h40 | 7'(ord);
        free_node[node_idx(hdr, ord)] = 1'b1;
        r.status = ST_OK;
        r.order = 5'(ord);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checker: one strobe, compared against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        grant_t want_r;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d addr %0d order %0d",
                       o_status, o_address_res, o_block_order);
                n_fail++;
            end else begin
                want_r = pending_results.pop_front();
                if (o_status !== want_r.status) begin
                    $error("status: expected %0d, got %0d", want_r.status, o_status);
                    n_fail++;
                end
                if (o_address_res !== want_r.addr) begin
                    $error("address_res: expected %0d, got %0d", want_r.addr, o_address_res);
                    n_fail++;
                end
                if (o_block_order !== want_r.order) begin
                    $error("block_order: expected %0d, got %0d", want_r.order, o_block_order);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog
    int unsigned cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------

    // Present one item and hold start until the block takes it. Start is left
    // high so a back-to-back item never toggles it within one step.
    task automatic send_item(logic kind, logic [16:0] size, logic [15:0] addr,
                             bit typed, grant_t typed_res);
        grant_t r;
        start          <= 1'b1;
        i_kind         <= kind;
        i_request_size <= size;
        i_address      <= addr;
        do @(posedge i_clk); while (busy);
        if (kind == KIND_ALLOC) begin
            r = model_alloc(size);
            if (r.status == ST_OK) live_grants.push_back(r.addr);
        end else begin
            r = model_free(addr);
            if (r.status == ST_OK && addr != 0) begin
                foreach (live_grants[i]) begin
                    if (live_grants[i] == addr) begin
                        live_grants.delete(i);
                        break;
                    end
                end
                stale_grants.push_back(addr);
                if (stale_grants.size() > 32) void'(stale_grants.pop_front());
            end
        end
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // Random pause between items: mostly none or short, occasionally long.
    task automatic sender_gap();
        int unsigned pick, n;
        pick = $urandom_range(99);
        if (!idle_gaps || pick < 40) return;
        n = (pick < 85) ? $urandom_range(1, 3) :
            (pick < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Register write while idle; a pool or minimum order write wipes every grant.
    task automatic write_cfg(logic [1:0] idx, logic [4:0] val);
        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_cfg(idx, val);
        if (idx == CFG_POOL_ORDER || idx == CFG_MIN_ORDER) begin
            live_grants.delete();
            stale_grants.delete();
        end
        @(posedge i_clk);
    endtask

    function automatic logic [16:0] pick_size();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 65) return 17'($urandom_range(1, 120));
        if (p < 88) return 17'($urandom_range(1, 1016));
        if (p < 97) return 17'($urandom_range(1, 65536));
        return 17'($urandom_range(0, 131071));
    endfunction

    // Mostly allocate/free pairs on live grants; the rest is noise and misuse.
    task automatic random_phase(int unsigned n_items);
        int unsigned p, k;
        grant_t none;
        none = '{ST_OK, 16'd0, 5'd0};
        for (int unsigned i = 0; i < n_items; i++) begin
            p = $urandom_range(99);
            if (p < 52 || (p < 88 && live_grants.size() == 0)) begin
                send_item(KIND_ALLOC, pick_size(), 16'($urandom), 1'b0, none);
            end else if (p < 88) begin
                k = $urandom_range(live_grants.size() - 1);
                send_item(KIND_FREE, 17'($urandom), live_grants[k], 1'b0, none);
            end else if (p < 93 && stale_grants.size() != 0) begin
                k = $urandom_range(stale_grants.size() - 1);
                send_item(KIND_FREE, 17'($urandom), stale_grants[k], 1'b0, none);
            end else if (p < 95) begin
                send_item(KIND_FREE, 17'($urandom), 16'd0, 1'b0, none);
            end else begin
                send_item(KIND_FREE, 17'($urandom), 16'($urandom), 1'b0, none);
            end
            if (i == n_items / 2) drain_results();   // sender waits out all results
            sender_gap();
        end
    endtask

    row_t rows[$];

    function automatic row_t mk(logic kind, int unsigned size, int unsigned addr,
                                bit typed, logic [1:0] st, int unsigned ad, int unsigned ord);
        row_t r;
        r.kind  = kind;
        r.size  = 17'(size);
        r.addr  = 16'(addr);
        r.typed = typed;
        r.res   = '{st, 16'(ad), 5'(ord)};
        return r;
    endfunction

    initial begin
        pool_ord     = POOL_ORDER_RST;
        unit_min_ord = MIN_UNIT_ORDER_DEF;
        clear_pool();

        // directed items on the reset pool: 1 KiB, 16-byte minimum
        rows.push_back(mk(KIND_ALLOC, 0,      0,     1, ST_FAIL,     0, 0));  // zero size
        rows.push_back(mk(KIND_ALLOC, 1017,   0,     1, ST_FAIL,     0, 0));  // just too big
        rows.push_back(mk(KIND_ALLOC, 65536,  0,     1, ST_FAIL,     0, 0));
        rows.push_back(mk(KIND_ALLOC, 131071, 65535, 1, ST_FAIL,     0, 0));
        rows.push_back(mk(KIND_FREE,  0,      0,     1, ST_OK,       0, 0));  // null pointer
        rows.push_back(mk(KIND_FREE,  131071, 4,     1, ST_BAD_FREE, 0, 0));  // below header
        rows.push_back(mk(KIND_FREE,  0,      9,     1, ST_BAD_FREE, 0, 0));  // misaligned
        rows.push_back(mk(KIND_FREE,  0,      65535, 1, ST_BAD_FREE, 0, 0));  // outside pool
        rows.push_back(mk(KIND_FREE,  0,      24,    1, ST_BAD_FREE, 0, 0));  // not a block
        rows.push_back(mk(KIND_FREE,  0,      8,     1, ST_BAD_FREE, 0, 0));  // free root
        rows.push_back(mk(KIND_ALLOC, 1016,   0,     1, ST_OK,       8, 10)); // whole pool
        rows.push_back(mk(KIND_ALLOC, 1,      0,     1, ST_FAIL,     0, 0));  // out of memory
        rows.push_back(mk(KIND_FREE,  0,      8,     1, ST_OK,       0, 10));
        rows.push_back(mk(KIND_ALLOC, 8,      0,     1, ST_OK,       8, 4));  // smallest block
        rows.push_back(mk(KIND_ALLOC, 9,      0,     0, ST_OK,       0, 0));
        rows.push_back(mk(KIND_ALLOC, 8,      0,     0, ST_OK,       0, 0));
        rows.push_back(mk(KIND_FREE,  0,      8,     0, ST_OK,       0, 0));
        rows.push_back(mk(KIND_FREE,  0,      8,     1, ST_BAD_FREE, 0, 0));  // double free
        rows.push_back(mk(KIND_ALLOC, 504,    0,     0, ST_OK,       0, 0));
        rows.push_back(mk(KIND_ALLOC, 500,    0,     0, ST_OK,       0, 0));
        rows.push_back(mk(KIND_FREE,  0,      40,    0, ST_OK,       0, 0));
        rows.push_back(mk(KIND_FREE,  0,      24,    0, ST_OK,       0, 0));
        rows.push_back(mk(KIND_ALLOC, 56,     0,     0, ST_OK,       0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_item(rows[i].kind, rows[i].size, rows[i].addr, rows[i].typed, rows[i].res);
            sender_gap();
        end
        random_phase(150);

        // largest pool, finest blocks
        write_cfg(CFG_POOL_ORDER, 5'd16);
        random_phase(170);

        // out-of-range values saturate; no gaps in this stretch
        write_cfg(CFG_POOL_ORDER, 5'd31);
        write_cfg(CFG_MIN_ORDER, 5'd0);
        idle_gaps = 1'b0;
        random_phase(130);
        idle_gaps = 1'b1;

        // coarse blocks: only 1 KiB units in a 1 KiB pool
        write_cfg(CFG_POOL_ORDER, 5'd0);
        write_cfg(CFG_MIN_ORDER, 5'd10);
        random_phase(80);

        write_cfg(CFG_MIN_ORDER, 5'd15);        // saturates to 10
        write_cfg(CFG_POOL_ORDER, 5'd13);
        random_phase(120);

        // unused indexes leave the pool alone
        write_cfg(CFG_SPARE_2, 5'd31);
        write_cfg(CFG_SPARE_3, 5'd21);
        write_cfg(CFG_MIN_ORDER, 5'd6);
        write_cfg(CFG_POOL_ORDER, 5'd12);
        random_phase(150);

        write_cfg(CFG_MIN_ORDER, 5'd4);
        write_cfg(CFG_POOL_ORDER, 5'd10);
        random_phase(130);

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* buddy_block_allocator.f */
rtl/bba_pkg.sv
rtl/buddy_block_allocator.sv
rtl/bba_chk.sv
dv/tb_buddy_block_allocator.sv
